// File: rtl/core/led_command_line_decoder_top_defines.svh
// Assertion macros for the LED command line decoder.
// Included by the top level; no other dependencies.
`ifndef LED_COMMAND_LINE_DECODER_TOP_DEFINES_SVH
`define LED_COMMAND_LINE_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checked property with a reset qualifier.
`define LCLD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds while reset is high.
`define LCLD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LCLD_ASSERT(lbl, clk, rst, prop, msg)
`define LCLD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// File: rtl/core/lcld_pkg.sv
// Shared types, character codes and keyword tables of the LED command line decoder.
// No dependencies; used by every module of the block.
package lcld_pkg;

   localparam int NumWords = 6;

   // Bit positions of the keyword candidates in the prefix flags.
   localparam int WordSversion = 0;
   localparam int WordLed      = 1;
   localparam int WordOff      = 2;
   localparam int WordOn       = 3;
   localparam int WordToggle   = 4;
   localparam int WordStatus   = 5;

   localparam logic [7:0] CharNul      = 8'h00;
   localparam logic [7:0] CharNewline  = 8'h0A;
   localparam logic [7:0] CharSpace    = 8'h20;
   localparam logic [7:0] CharDigitLo  = 8'h33;  // '3'
   localparam logic [7:0] CharDigitHi  = 8'h36;  // '6'
   localparam logic [7:0] CharLowerA   = 8'h61;
   localparam logic [7:0] CharLowerZ   = 8'h7A;
   localparam logic [7:0] CaseOffset   = 8'h20;

   localparam logic [3:0] MaxCharPos   = 4'd15;
   localparam logic [3:0] LedDigitPos  = 4'd3;
   localparam logic [3:0] LedTokenLen  = 4'd4;

   // Keyword text, padded with zeros; only the first WordLen characters count.
   localparam logic [7:0] WordText [NumWords][8] = '{
      '{8'h53, 8'h56, 8'h45, 8'h52, 8'h53, 8'h49, 8'h4F, 8'h4E},  // SVERSION
      '{8'h4C, 8'h45, 8'h44, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // LED
      '{8'h4F, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // OFF
      '{8'h4F, 8'h4E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // ON
      '{8'h54, 8'h4F, 8'h47, 8'h47, 8'h4C, 8'h45, 8'h00, 8'h00},  // TOGGLE
      '{8'h53, 8'h54, 8'h41, 8'h54, 8'h55, 8'h53, 8'h00, 8'h00}   // STATUS
   };
   localparam logic [3:0] WordLen [NumWords] = '{4'd8, 4'd3, 4'd3, 4'd2, 4'd6, 4'd6};

   typedef enum logic [2:0] {
      ACT_ERROR   = 3'd0,
      ACT_VERSION = 3'd1,
      ACT_OFF     = 3'd2,
      ACT_ON      = 3'd3,
      ACT_TOGGLE  = 3'd4,
      ACT_STATUS  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      KIND_OTHER   = 2'd0,
      KIND_VERSION = 2'd1,
      KIND_LED     = 2'd2
   } kind_type;

   // One accepted input transaction.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } item_type;

   // Per-line parse state.
   typedef struct packed {
      logic [1:0]          token_count;
      logic                in_token;
      logic [3:0]          char_position;
      logic [NumWords-1:0] prefix_flags;
      kind_type            first_kind;
      logic [1:0]          led_digit;
      action_type          verb_code;
      logic                error_flag;
   } state_type;

   // One decoded command.
   typedef struct packed {
      action_type action;
      logic [1:0] led_index;
   } result_type;

   localparam state_type StateReset = '{
      token_count:   2'd0,
      in_token:      1'b0,
      char_position: 4'd0,
      prefix_flags:  {NumWords{1'b1}},
      first_kind:    KIND_OTHER,
      led_digit:     2'd0,
      verb_code:     ACT_ERROR,
      error_flag:    1'b0
   };

endpackage

// File: rtl/core/lcld_in_stage.sv
// Input register of the LED command line decoder: holds one request transaction.
// Depends on lcld_pkg.
module lcld_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_in_byte,
   input  logic              req_last_byte,
   input  logic              advance,
   output logic              item_valid,
   output lcld_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   lcld_pkg::item_type item_ff;
   logic               accept;

   // The held item leaves whenever the core advances, so a new one may enter
   // in the same cycle.
   assign req_stall = valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.in_byte   <= req_in_byte;
         item_ff.last_byte <= req_last_byte;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/core/lcld_decode.sv
// Single-pass character step of the LED command line decoder: next parse state
// and the decoded command on the final character. Depends on lcld_pkg.
module lcld_decode (
   input  lcld_pkg::state_type  state,
   input  lcld_pkg::item_type   item,
   output lcld_pkg::state_type  next_state,
   output lcld_pkg::result_type result
);

   function automatic logic word_matched(lcld_pkg::state_type s, int w);
      return s.prefix_flags[w] && (s.char_position >= lcld_pkg::WordLen[w]);
   endfunction

   // Closes the current token and records what it meant.
   function automatic lcld_pkg::state_type finish_token(lcld_pkg::state_type s);
      lcld_pkg::state_type r;
      r = s;
      if (s.token_count == 2'd1) begin
         if (word_matched(s, lcld_pkg::WordSversion)) begin
            r.first_kind = lcld_pkg::KIND_VERSION;
         end else if (word_matched(s, lcld_pkg::WordLed) &&
                      s.char_position == lcld_pkg::LedTokenLen && !s.error_flag) begin
            r.first_kind = lcld_pkg::KIND_LED;
         end else begin
            r.first_kind = lcld_pkg::KIND_OTHER;
         end
      end else if (s.token_count == 2'd2) begin
         // Later keywords win, as STATUS overrides everything before it.
         r.verb_code = lcld_pkg::ACT_ERROR;
         if (word_matched(s, lcld_pkg::WordOff))    r.verb_code = lcld_pkg::ACT_OFF;
         if (word_matched(s, lcld_pkg::WordOn))     r.verb_code = lcld_pkg::ACT_ON;
         if (word_matched(s, lcld_pkg::WordToggle)) r.verb_code = lcld_pkg::ACT_TOGGLE;
         if (word_matched(s, lcld_pkg::WordStatus)) r.verb_code = lcld_pkg::ACT_STATUS;
      end
      r.in_token = 1'b0;
      return r;
   endfunction

   always_comb begin
      logic [7:0]          c;
      logic                sep;
      lcld_pkg::state_type s;

      c = item.in_byte;
      if (c >= lcld_pkg::CharLowerA && c <= lcld_pkg::CharLowerZ) begin
         c = c - lcld_pkg::CaseOffset;
      end
      sep = (c == lcld_pkg::CharSpace) || (c == lcld_pkg::CharNewline) ||
            (c == lcld_pkg::CharNul);
      s = state;

      if (sep) begin
         if (s.in_token) begin
            s = finish_token(s);
         end
      end else begin
         if (!s.in_token) begin
            s.in_token = 1'b1;
            if (s.token_count != 2'd3) begin
               s.token_count = s.token_count + 2'd1;
            end
            s.char_position = '0;
            s.prefix_flags  = '1;
         end
         for (int w = 0; w < lcld_pkg::NumWords; w++) begin
            if (s.char_position < lcld_pkg::WordLen[w] &&
                lcld_pkg::WordText[w][s.char_position[2:0]] != c) begin
               s.prefix_flags[w] = 1'b0;
            end
         end
         if (s.token_count == 2'd1 && s.char_position == lcld_pkg::LedDigitPos) begin
            if (c >= lcld_pkg::CharDigitLo && c <= lcld_pkg::CharDigitHi) begin
               s.led_digit  = 2'(c - lcld_pkg::CharDigitLo);
               s.error_flag = 1'b0;
            end else begin
               s.led_digit  = 2'd0;
               s.error_flag = 1'b1;
            end
         end
         if (s.char_position != lcld_pkg::MaxCharPos) begin
            s.char_position = s.char_position + 4'd1;
         end
      end

      result.action    = lcld_pkg::ACT_ERROR;
      result.led_index = 2'd0;
      if (item.last_byte) begin
         if (s.in_token) begin
            s = finish_token(s);
         end
         if (s.first_kind == lcld_pkg::KIND_VERSION && s.token_count == 2'd1) begin
            result.action = lcld_pkg::ACT_VERSION;
         end else if (s.first_kind == lcld_pkg::KIND_LED && s.token_count == 2'd2 &&
                      s.verb_code != lcld_pkg::ACT_ERROR) begin
            result.action    = s.verb_code;
            result.led_index = s.led_digit;
         end
         s = lcld_pkg::StateReset;
      end

      next_state = s;
   end

endmodule

// File: rtl/core/lcld_out_stage.sv
// Result register of the LED command line decoder: holds one response
// transaction until it is taken. Depends on lcld_pkg.
module lcld_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  lcld_pkg::result_type result,
   output logic                 out_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_action,
   output logic [1:0]           rsp_led_index
);

   logic                 valid_ff;
   logic                 valid_in;
   lcld_pkg::result_type result_ff;

   assign out_ready = !valid_ff || !rsp_stall;
   assign valid_in  = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_action    = result_ff.action;
   assign rsp_led_index = result_ff.led_index;

endmodule

// File: rtl/core/led_command_line_decoder_top.sv
// Top level of the LED command line decoder: input register, character step,
// parse state register and result register. Depends on lcld_pkg and the defines header.
//
//   Channel  Ports                                  Direction  Moves
//   req      req_valid, req_stall, req_in_byte,     in         one character per transaction
//            req_last_byte
//   rsp      rsp_valid, rsp_stall, rsp_action,      out        one decoded command per line
//            rsp_led_index
//
// Each character transaction is held in the input register; the
// character step is one combinational pass that updates the parse state and,
// on the final character, loads the result register. The sustained rate is one
// character per cycle unless a final character is held by a stalled response.
// A command appears on rsp once the result register has been loaded with it.
// Reset is synchronous and active high; it empties both registers and returns
// the parse state to its start-of-line value.
// A stalled response blocks only a final character that would overwrite it;
// other characters keep flowing while the response waits.
`include "led_command_line_decoder_top_defines.svh"

module led_command_line_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_action,
   output logic [1:0] rsp_led_index
);

   logic                 stage_valid;
   lcld_pkg::item_type   stage_item;
   logic                 advance;
   logic                 out_ready;
   logic                 out_load;
   lcld_pkg::state_type  state_ff;
   lcld_pkg::state_type  state_in;
   lcld_pkg::result_type step_result;

   // The held character may be processed unless it ends a line and the
   // result register still holds a command nobody has taken.
   assign advance  = stage_valid && (!stage_item.last_byte || out_ready);
   assign out_load = advance && stage_item.last_byte;

   lcld_in_stage u_in_stage (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .advance       (advance),
      .item_valid    (stage_valid),
      .item          (stage_item)
   );

   lcld_decode u_decode (
      .state      (state_ff),
      .item       (stage_item),
      .next_state (state_in),
      .result     (step_result)
   );

   // The parse state changes only when a character is actually consumed.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcld_pkg::StateReset;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   lcld_out_stage u_out_stage (
      .clock         (clock),
      .reset         (reset),
      .load          (out_load),
      .result        (step_result),
      .out_ready     (out_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_action    (rsp_action),
      .rsp_led_index (rsp_led_index)
   );

   // A finished line always leaves the parser at its start-of-line state.
   `LCLD_ASSERT(a_line_end_clears, clock, reset, out_load |=> state_ff == lcld_pkg::StateReset, "parse state not cleared after final character")

   // Only LED actions carry an LED number.
   `LCLD_ASSERT(a_number_only_led, clock, reset, rsp_valid && (rsp_action == lcld_pkg::ACT_ERROR || rsp_action == lcld_pkg::ACT_VERSION) |-> rsp_led_index == 2'd0, "LED number set on a non-LED command")

   // Backpressure is raised only while a character is held.
   `LCLD_ASSERT_ALWAYS(a_stall_needs_item, clock, req_stall |-> stage_valid, "request stalled with empty input register")

   // Being inside a token means at least one token has started.
   `LCLD_ASSERT(a_token_counted, clock, reset, state_ff.in_token |-> state_ff.token_count != 2'd0, "token open with zero token count")

endmodule
